/* src/tes_pkg.sv */
// shared types, constants and helpers of the text encoding sniffer
package tes_pkg;

    localparam int COUNT_BITS = 24;
    localparam int POS_BITS   = 25;
    localparam int CONF_BITS  = 24;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [POS_BITS-1:0]   POS_MAX = {POS_BITS{1'b1}};

    // configuration register indexes
    localparam logic [1:0] CFG_SAMPLE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_AUTO_DETECT  = 2'd1;
    localparam logic [1:0] CFG_FORCED_ENC   = 2'd2;

    // encoding codes
    localparam logic [2:0] ENC_ASCII   = 3'd0;
    localparam logic [2:0] ENC_UTF8    = 3'd1;
    localparam logic [2:0] ENC_UTF8BOM = 3'd2;
    localparam logic [2:0] ENC_LATIN1  = 3'd3;

    // how the verdict was reached
    localparam logic [2:0] HOW_FORCED   = 3'd0;
    localparam logic [2:0] HOW_ASSUMED  = 3'd1;
    localparam logic [2:0] HOW_BOM      = 3'd2;
    localparam logic [2:0] HOW_ASCII    = 3'd3;
    localparam logic [2:0] HOW_UTF8     = 3'd4;
    localparam logic [2:0] HOW_LATIN1   = 3'd5;
    localparam logic [2:0] HOW_FALLBACK = 3'd6;

    localparam logic [2:0] FORCED_MIN = 3'd1;
    localparam logic [2:0] FORCED_MAX = 3'd5;

    localparam logic [7:0] BOM_B0 = 8'hEF;
    localparam logic [7:0] BOM_B1 = 8'hBB;
    localparam logic [7:0] BOM_B2 = 8'hBF;

    // bit n set: byte 0x80+n is a printable high byte
    localparam logic [31:0] PRINTABLE_C1 = 32'hDEFE5EFD;

    typedef struct packed {
        logic                  bom_hit;
        logic [COUNT_BITS-1:0] valid_seq;
        logic [COUNT_BITS-1:0] mb_starts;
        logic [COUNT_BITS-1:0] high_cnt;
        logic [COUNT_BITS-1:0] printable;
    } t_snap;

    typedef struct packed {
        logic [2:0]           encoding;
        logic [2:0]           how_decided;
        logic [CONF_BITS-1:0] conf_num;
        logic [CONF_BITS-1:0] conf_den;
    } t_result;

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] cnt,
                                                      input logic [1:0] inc);
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, cnt} + {{(COUNT_BITS-1){1'b0}}, inc};
        if (sum[COUNT_BITS]) begin
            return CNT_MAX;
        end
        return sum[COUNT_BITS-1:0];
    endfunction

endpackage

/* src/tes_scan.sv */
// per-byte tracker: bom match, utf-8 sequence state and the sample counters
module tes_scan import tes_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [23:0] i_sample_limit,
    output t_snap       o_snap
);

    logic [POS_BITS-1:0]   r_pos,     n_pos;
    logic [1:0]            r_bom,     n_bom;
    logic [1:0]            r_rem,     n_rem;
    logic [1:0]            r_rescan,  n_rescan;
    logic [COUNT_BITS-1:0] r_valid,   n_valid;
    logic [COUNT_BITS-1:0] r_starts,  n_starts;
    logic [COUNT_BITS-1:0] r_high,    n_high;
    logic [COUNT_BITS-1:0] r_print,   n_print;

    logic       in_sample;
    logic       is_cont;
    logic       is_high;
    logic       printable;
    logic [1:0] lead_len;
    logic [7:0] bom_byte;
    logic [1:0] fail_inc;
    logic [1:0] start_inc;
    logic [1:0] end_inc;
    logic [1:0] rem_dec;
    logic       valid_inc;

    always_comb begin
        in_sample = r_pos < {{(POS_BITS-24){1'b0}}, i_sample_limit};
        is_high   = i_byte[7];
        is_cont   = i_byte[7:6] == 2'b10;
        printable = (i_byte >= 8'hA0) || PRINTABLE_C1[i_byte[4:0]];

        priority if (i_byte[7:5] == 3'b110) begin
            lead_len = 2'd1;
        end else if (i_byte[7:4] == 4'b1110) begin
            lead_len = 2'd2;
        end else if (i_byte[7:3] == 5'b11110) begin
            lead_len = 2'd3;
        end else begin
            lead_len = 2'd0;
        end

        unique case (r_pos[1:0])
            2'd0:    bom_byte = BOM_B0;
            2'd1:    bom_byte = BOM_B1;
            default: bom_byte = BOM_B2;
        endcase

        n_bom = r_bom;
        if (r_pos < POS_BITS'(3) && {{(POS_BITS-2){1'b0}}, r_bom} == r_pos
                && i_byte == bom_byte) begin
            n_bom = r_bom + 2'd1;
        end

        n_high  = r_high;
        n_print = r_print;
        if (in_sample && is_high) begin
            n_high = sat_add(r_high, 2'd1);
            if (printable) begin
                n_print = sat_add(r_print, 2'd1);
            end
        end

        fail_inc  = 2'd0;
        start_inc = 2'd0;
        valid_inc = 1'b0;
        rem_dec   = r_rem - 2'd1;
        n_rem     = r_rem;
        n_rescan  = r_rescan;
        if (r_rem != 2'd0 && is_cont) begin
            n_rem = rem_dec;
            if (rem_dec == 2'd0) begin
                valid_inc = 1'b1;
                n_rescan  = 2'd0;
            end else if (in_sample) begin
                n_rescan = r_rescan + 2'd1;
            end
        end else begin
            // broken sequence: matched continuations count as bad starts
            if (r_rem != 2'd0) begin
                fail_inc = r_rescan;
            end
            n_rescan = 2'd0;
            n_rem    = 2'd0;
            if (in_sample && is_high) begin
                start_inc = 2'd1;
                n_rem     = lead_len;
            end
        end

        // file ends inside a sequence
        end_inc = (i_last && n_rem != 2'd0) ? n_rescan : 2'd0;

        n_valid  = valid_inc ? sat_add(r_valid, 2'd1) : r_valid;
        n_starts = sat_add(r_starts, fail_inc + start_inc + end_inc);
        n_pos    = (r_pos != POS_MAX) ? r_pos + POS_BITS'(1) : r_pos;

        o_snap.bom_hit   = n_bom == 2'd3;
        o_snap.valid_seq = n_valid;
        o_snap.mb_starts = n_starts;
        o_snap.high_cnt  = n_high;
        o_snap.printable = n_print;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_pos    <= '0;
            r_bom    <= '0;
            r_rem    <= '0;
            r_rescan <= '0;
            r_valid  <= '0;
            r_starts <= '0;
            r_high   <= '0;
            r_print  <= '0;
        end else if (i_en) begin
            r_pos    <= n_pos;
            r_bom    <= n_bom;
            r_rem    <= n_rem;
            r_rescan <= n_rescan;
            r_valid  <= n_valid;
            r_starts <= n_starts;
            r_high   <= n_high;
            r_print  <= n_print;
        end
    end

endmodule

/* src/tes_verdict.sv */
// verdict logic: picks encoding and confidence from the final counts
module tes_verdict import tes_pkg::*; (
    input  t_snap      i_snap,
    input  logic       i_auto_detect,
    input  logic [2:0] i_forced,
    output t_result    o_result
);

    logic [COUNT_BITS+2:0] valid_x5;
    logic [COUNT_BITS+2:0] starts_x4;
    logic [COUNT_BITS+3:0] print_x10;
    logic [COUNT_BITS+3:0] high_x7;
    logic                  utf8_ok;
    logic                  latin_ok;

    always_comb begin
        valid_x5  = {1'b0, i_snap.valid_seq, 2'b00} + {3'b000, i_snap.valid_seq};
        starts_x4 = {1'b0, i_snap.mb_starts, 2'b00};
        print_x10 = {1'b0, i_snap.printable, 3'b000} + {3'b000, i_snap.printable, 1'b0};
        high_x7   = {1'b0, i_snap.high_cnt, 3'b000} - {4'b0000, i_snap.high_cnt};
        utf8_ok   = (i_snap.mb_starts != '0) && (valid_x5 > starts_x4);
        latin_ok  = print_x10 > high_x7;

        o_result.conf_num = CONF_BITS'(1);
        o_result.conf_den = CONF_BITS'(1);
        priority if (i_forced >= FORCED_MIN && i_forced <= FORCED_MAX) begin
            o_result.encoding    = i_forced - 3'd1;
            o_result.how_decided = HOW_FORCED;
        end else if (!i_auto_detect) begin
            o_result.encoding    = ENC_UTF8;
            o_result.how_decided = HOW_ASSUMED;
        end else if (i_snap.bom_hit) begin
            o_result.encoding    = ENC_UTF8BOM;
            o_result.how_decided = HOW_BOM;
        end else if (i_snap.high_cnt == '0) begin
            o_result.encoding    = ENC_ASCII;
            o_result.how_decided = HOW_ASCII;
        end else if (utf8_ok) begin
            o_result.encoding    = ENC_UTF8;
            o_result.how_decided = HOW_UTF8;
            o_result.conf_num    = i_snap.valid_seq[CONF_BITS-1:0];
            o_result.conf_den    = i_snap.mb_starts[CONF_BITS-1:0];
        end else if (latin_ok) begin
            o_result.encoding    = ENC_LATIN1;
            o_result.how_decided = HOW_LATIN1;
            o_result.conf_num    = i_snap.printable[CONF_BITS-1:0];
            o_result.conf_den    = i_snap.high_cnt[CONF_BITS-1:0];
        end else begin
            o_result.encoding    = ENC_LATIN1;
            o_result.how_decided = HOW_FALLBACK;
            o_result.conf_den    = CONF_BITS'(2);
        end
    end

endmodule

/* src/text_encoding_sniffer.sv */
// top level of the text encoding sniffer: byte stream in, one verdict per file out
//
// Takes one file byte per cycle on the slave stream (tlast marks the final byte)
// and gives one verdict word per file on the master stream. The final byte passes
// through the input register, then its counter update is loaded into a final-count
// register, and then the verdict logic is loaded into the output register.
// Throughput is one byte per clock; bytes keep flowing while a verdict waits on
// the output, and the input holds off only when a second file ends while the
// previous verdict is still waiting to be taken and the final-count register is
// full. Configuration is written through a plain write port; the user must write
// it only while no file is in flight, and the block itself does not enforce this;
// a file must end with tlast before its counts are reported and cleared.
module text_encoding_sniffer import tes_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    // byte stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] byte_value
    input  logic        i_s_tlast,   // last_byte
    // verdict stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata    // [2:0] encoding, [5:3] how_decided,
                                     // [29:6] confidence_num, [53:30] confidence_den
);

    logic [23:0] r_sample_limit;
    logic        r_auto_detect;
    logic [2:0]  r_forced;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    logic        r_snap_valid;
    t_snap       r_snap;
    t_snap       n_snap;

    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;

    logic        out_free;
    logic        snap_move;
    logic        snap_free;
    logic        proc_ok;
    logic        in_free;

    always_comb begin
        out_free  = !r_out_valid || i_m_tready;
        snap_move = r_snap_valid && out_free;
        snap_free = !r_snap_valid || out_free;
        // non-final bytes never wait on the verdict path
        proc_ok   = r_in_valid && (!r_in_last || snap_free);
        in_free   = !r_in_valid || proc_ok;
    end

    assign o_s_tready = in_free;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out.conf_den, r_out.conf_num,
                         r_out.how_decided, r_out.encoding};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_limit <= 24'd4096;
            r_auto_detect  <= 1'b1;
            r_forced       <= 3'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SAMPLE_LIMIT: r_sample_limit <= i_cfg_data;
                CFG_AUTO_DETECT:  r_auto_detect  <= i_cfg_data[0];
                CFG_FORCED_ENC:   r_forced       <= i_cfg_data[2:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_s_tvalid;
        end
        if (in_free && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    tes_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (proc_ok),
        .i_byte         (r_in_byte),
        .i_last         (r_in_last),
        .i_sample_limit (r_sample_limit),
        .o_snap         (n_snap)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (proc_ok && r_in_last) begin
            r_snap_valid <= 1'b1;
        end else if (snap_move) begin
            r_snap_valid <= 1'b0;
        end
        if (proc_ok && r_in_last) begin
            r_snap <= n_snap;
        end
    end

    tes_verdict u_verdict (
        .i_snap        (r_snap),
        .i_auto_detect (r_auto_detect),
        .i_forced      (r_forced),
        .o_result      (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_snap_valid;
        end
        if (snap_move) begin
            r_out <= n_out;
        end
    end

endmodule
